// ===== hdl/sida_pkg.sv =====
// Shared types and constants for the signed integer to decimal ASCII unit.
// Holds the digit cell control struct and the ASCII character codes.
// No dependencies; compiled first.
package sida_pkg;

	// One BCD digit per cell.
	localparam int DIGIT_W = 4;
	// Width of the character code on the result port.
	localparam int CHAR_W = 6;

	localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

	// Control shared by every cell of the digit row.
	typedef struct packed {
		logic clear;    // zero the digit
		logic dabble;   // add-3 adjust and shift in one binary bit
		logic shift_up; // move digits one place toward the most significant end
	} cell_ctl_t;

endpackage

// ===== hdl/sida_cell.sv =====
// One BCD digit cell of the conversion row.
// Performs the shift-and-add-3 step and the digit shift used while emitting.
// Depends on sida_pkg.
module sida_cell (
	input  logic                         clk,
	input  sida_pkg::cell_ctl_t          ctl,
	input  logic                         carry_in,
	input  logic [sida_pkg::DIGIT_W-1:0] digit_in,
	output logic                         carry_out,
	output logic [sida_pkg::DIGIT_W-1:0] digit_q
);
	import sida_pkg::*;

	logic [DIGIT_W-1:0] adj;

	// Digits of five or more get three added so the shift carries correctly.
	always_comb begin
		if (digit_q >= DIGIT_W'(5)) begin
			adj = digit_q + DIGIT_W'(3);
		end else begin
			adj = digit_q;
		end
	end

	assign carry_out = adj[DIGIT_W-1];

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			digit_q <= '0;
		end else if (ctl.dabble) begin
			digit_q <= {adj[DIGIT_W-2:0], carry_in};
		end else if (ctl.shift_up) begin
			digit_q <= digit_in;
		end
	end

endmodule

// ===== hdl/signed_int_to_decimal_ascii_unit.sv =====
// Signed integer to decimal ASCII unit on a row of BCD digit cells; uses sida_cell and sida_pkg.
// The minus sign is registered at acceptance; each digit is registered as the top cell is read out,
// with leading zeros skipped. Busy stays high through the bit-serial shift through the digit
// cell row and the digit read-out, and no new item is taken until the unit is idle again.
// The receiver cannot stall. Reset (arst_n low, asynchronous) returns to idle, no strobe pending.
module signed_int_to_decimal_ascii_unit #(
	parameter int NUM_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [NUM_WIDTH-1:0]   number,
	output logic                          strobe,
	output logic [sida_pkg::CHAR_W-1:0]   char_code,
	output logic                          last_char
);
	import sida_pkg::*;

	// Decimal digits in 2^(NUM_WIDTH-1), the largest magnitude; log10(2) ~ 0.30103.
	localparam int NDIG = ((NUM_WIDTH - 1) * 30103) / 100000 + 1;
	localparam int CW   = $clog2(NUM_WIDTH + 1);
	localparam int LW   = $clog2(NDIG + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_LEAD,
		ST_EMIT
	} state_t;

	state_t                 state_q;
	logic [NUM_WIDTH-1:0]   mag_q;
	logic [CW-1:0]          bits_left_q;
	logic [LW-1:0]          digits_left_q;
	logic                   strobe_q;
	logic [CHAR_W-1:0]      char_q;
	logic                   last_q;

	logic                   accept;
	logic [NUM_WIDTH-1:0]   mag_in;
	cell_ctl_t              ctl;
	logic [DIGIT_W-1:0]     digit [NDIG];
	logic [NDIG:0]          carry;
	logic [DIGIT_W-1:0]     top_digit;
	logic                   lead_zero;
	logic                   emit_now;
	logic                   final_digit;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Magnitude in NUM_WIDTH unsigned bits: the most negative value maps to
	// 2^(NUM_WIDTH-1), which still fits, so nothing overflows.
	assign mag_in = number[NUM_WIDTH-1] ? (~number + 1'b1) : number;

	assign top_digit   = digit[NDIG-1];
	assign final_digit = (digits_left_q == LW'(1));
	// A leading zero is skipped unless it is the only digit left (value zero).
	assign lead_zero   = (state_q == ST_LEAD) && (top_digit == '0) && !final_digit;
	assign emit_now    = ((state_q == ST_LEAD) && !lead_zero) || (state_q == ST_EMIT);

	always_comb begin
		ctl.clear    = accept;
		ctl.dabble   = (state_q == ST_CONV);
		ctl.shift_up = lead_zero || emit_now;
	end

	// The binary magnitude enters the row most significant bit first at digit zero.
	assign carry[0] = mag_q[NUM_WIDTH-1];

	// Cell 0 holds the units digit. While emitting, each cell takes the digit of
	// the cell below it so the most significant digit always sits in the top cell.
	for (genvar i = 0; i < NDIG; i++) begin : g_cell
		logic [DIGIT_W-1:0] below;
		if (i == 0) begin : g_bottom
			assign below = '0;
		end else begin : g_upper
			assign below = digit[i-1];
		end
		sida_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.carry_in (carry[i]),
			.digit_in (below),
			.carry_out(carry[i+1]),
			.digit_q  (digit[i])
		);
	end

	// Payload register: magnitude shifter.
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= mag_in;
		end else if (state_q == ST_CONV) begin
			mag_q <= {mag_q[NUM_WIDTH-2:0], 1'b0};
		end
	end

	// Sequencer: state, counters and the registered character, strobe and last flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			bits_left_q   <= '0;
			digits_left_q <= '0;
			strobe_q      <= 1'b0;
			char_q        <= '0;
			last_q        <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q     <= ST_CONV;
						bits_left_q <= CW'(NUM_WIDTH);
						// A negative number starts its text with the minus sign now.
						char_q      <= CHAR_MINUS;
						strobe_q    <= number[NUM_WIDTH-1];
					end
				end
				ST_CONV: begin
					bits_left_q <= bits_left_q - 1'b1;
					if (bits_left_q == CW'(1)) begin
						state_q       <= ST_LEAD;
						digits_left_q <= LW'(NDIG);
					end
				end
				ST_LEAD, ST_EMIT: begin
					digits_left_q <= digits_left_q - 1'b1;
					if (emit_now) begin
						char_q   <= CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
						strobe_q <= 1'b1;
						last_q   <= final_digit;
						state_q  <= final_digit ? ST_IDLE : ST_EMIT;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign strobe    = strobe_q;
	assign char_code = char_q;
	assign last_char = last_q;

`ifndef NO_ASSERTIONS
	// Every shown character is a minus sign or a decimal digit.
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (char_code == CHAR_MINUS) ||
			((char_code >= CHAR_ZERO) && (char_code <= CHAR_ZERO + 6'd9)))
		else $error("character code out of range");

	// The last-character flag only appears on a shown character.
	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last_char |-> strobe)
		else $error("last_char without strobe");

	// The unit goes idle exactly when it shows the final character.
	a_idle_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (strobe && last_char))
		else $error("went idle without the final character");

	// An accepted item keeps the unit busy for the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not make the unit busy");

	// The top digit stays a valid BCD digit while digits are read out.
	a_bcd_top: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_LEAD) || (state_q == ST_EMIT)) |-> (top_digit <= DIGIT_W'(9)))
		else $error("top cell holds a non-decimal digit");

	// Every magnitude fits in the row, so the top cell never carries out while converting.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV) |-> !carry[NDIG])
		else $error("digit row overflowed during conversion");
`endif

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for signed_int_to_decimal_ascii_unit.
// Drives signed numbers through the start/busy handshake and checks every strobed character.
// Depends on sida_pkg (hdl/sida_pkg.sv) and the unit itself.
`timescale 1ns / 100ps

module tb;
	import sida_pkg::*;

	localparam int NUM_WIDTH = 32;
	// The slowest correct item waits out the whole busy window and the longest sender gap
	// and shows eleven characters. About 460 items at that pace stay well below this limit.
	localparam int CYCLE_LIMIT = 400000;
	// Longest distance between acceptance and the final character, with margin.
	localparam int DRAIN_CYCLES = 3 * (NUM_WIDTH + 12);
	localparam int MAX_PRINTED = 30;

	// One character of decimal text as the unit should present it.
	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} text_char_t;

	logic                        clk;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic signed [NUM_WIDTH-1:0] number;
	logic                        strobe;
	logic [CHAR_W-1:0]           char_code;
	logic                        last_char;

	// Characters still owed by the unit, oldest first.
	text_char_t expected_text[$];

	int  mismatches = 0;
	int  numbers_sent = 0;
	int  negatives_sent = 0;
	int  chars_checked = 0;
	int  longest_text = 0;
	int  cycle_count = 0;
	// When clear, the sender presents each number as soon as it may.
	bit  idle_enabled = 1'b0;

	signed_int_to_decimal_ascii_unit #(
		.NUM_WIDTH(NUM_WIDTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.number   (number),
		.strobe   (strobe),
		.char_code(char_code),
		.last_char(last_char)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Prints one line per mismatch, up to a cap, and counts all of them.
	task automatic report_mismatch(input string what);
		if (mismatches < MAX_PRINTED)
			$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	// Works out the decimal text of one number. The magnitude is taken as an
	// unsigned value of the full width, so the most negative number negates to
	// 2^(NUM_WIDTH-1) exactly instead of overflowing.
	function automatic void predict_text(input logic [NUM_WIDTH-1:0] value);
		logic                 negative;
		logic [NUM_WIDTH-1:0] magnitude;
		logic [63:0]          rest;
		logic [3:0]           digits[$];
		text_char_t           entry;
		int                   length;
		negative = value[NUM_WIDTH-1];
		magnitude = negative ? (~value + 1'b1) : value;
		rest = 64'(magnitude);
		// Zero still yields one digit, hence the loop runs at least once.
		do begin
			digits.push_front(4'(rest % 10));
			rest = rest / 10;
		end while (rest != 0);
		length = digits.size();
		if (negative) begin
			entry.code = CHAR_MINUS;
			entry.last = 1'b0;
			expected_text.push_back(entry);
			length++;
		end
		foreach (digits[i]) begin
			entry.code = CHAR_ZERO + CHAR_W'(digits[i]);
			entry.last = (i == digits.size() - 1);
			expected_text.push_back(entry);
		end
		if (length > longest_text)
			longest_text = length;
	endfunction

	// Sender gap: mostly none or short, now and then long enough to outlast
	// the whole busy window so that start rises on an idle unit.
	function automatic int idle_cycles();
		int roll;
		roll = $urandom_range(99, 0);
		if (roll < 50)
			return 0;
		if (roll < 80)
			return $urandom_range(4, 1);
		if (roll < 95)
			return $urandom_range(45, 5);
		return $urandom_range(150, 46);
	endfunction

	// Presents one item and waits for the edge that accepts it. Start is
	// dropped at the next falling edge; the unit is busy for many cycles after
	// acceptance, so this costs no throughput, and the next call raises start
	// again while busy is still high when there is no gap.
	task automatic send_number(input logic [NUM_WIDTH-1:0] value);
		int gap;
		gap = idle_enabled ? idle_cycles() : 0;
		@(negedge clk);
		repeat (gap) @(negedge clk);
		start <= 1'b1;
		number <= value;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		predict_text(value);
		numbers_sent++;
		if (value[NUM_WIDTH-1])
			negatives_sent++;
		@(negedge clk);
		start <= 1'b0;
		// Junk on the number port while start is low must be ignored.
		number <= $urandom;
	endtask

	// Extremes, zero, single digits, several power-of-ten boundaries that change
	// the text length, and the most negative value that cannot be negated in
	// the input width.
	task automatic test_corner_numbers();
		int corners[$];
		corners = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100,
			999999999, 1000000000, -999999999, -1000000000,
			2147483647, 2147483646, -2147483647, int'(32'sh80000000),
			int'(32'h55555555), int'(32'hAAAAAAAA), 1000000007, -5};
		idle_enabled = 1'b0;
		foreach (corners[i])
			send_number(corners[i]);
	endtask

	// Picks a text length first, then a magnitude of that length, so that short
	// and long texts are equally common. One pick in five lands on one end of
	// its decade. Idling is switched on and off in runs of forty items.
	task automatic test_random_lengths(input int count);
		int                   digit_count;
		bit                   negative;
		int                   pick;
		longint unsigned      low_mag;
		longint unsigned      high_mag;
		longint unsigned      top;
		longint unsigned      magnitude;
		logic [NUM_WIDTH-1:0] value;
		for (int i = 0; i < count; i++) begin
			idle_enabled = ((i / 40) % 2) == 0;
			negative = 1'($urandom_range(1, 0));
			digit_count = $urandom_range(10, 1);
			top = 1;
			repeat (digit_count) top = top * 10;
			low_mag = (digit_count == 1) ? 0 : top / 10;
			high_mag = top - 1;
			// The negative side reaches one further than the positive side.
			if (negative && high_mag > (64'd1 << (NUM_WIDTH - 1)))
				high_mag = 64'd1 << (NUM_WIDTH - 1);
			if (!negative && high_mag > (64'd1 << (NUM_WIDTH - 1)) - 1)
				high_mag = (64'd1 << (NUM_WIDTH - 1)) - 1;
			pick = $urandom_range(9, 0);
			if (pick == 0)
				magnitude = low_mag;
			else if (pick == 1)
				magnitude = high_mag;
			else
				magnitude = low_mag + ({$urandom, $urandom} % (high_mag - low_mag + 1));
			value = magnitude[NUM_WIDTH-1:0];
			if (negative)
				value = ~value + 1'b1;
			send_number(value);
		end
	endtask

	// Raw bit patterns, so that every input bit is seen at both values.
	task automatic test_random_patterns(input int count);
		idle_enabled = 1'b1;
		repeat (count)
			send_number(NUM_WIDTH'($urandom));
	endtask

	// Compares every strobed character with the oldest one still owed.
	always @(posedge clk) begin : check_text
		text_char_t want;
		if (arst_n && strobe) begin
			if (expected_text.size() == 0) begin
				report_mismatch($sformatf("character %0d with none expected", char_code));
			end else begin
				want = expected_text.pop_front();
				if (char_code !== want.code)
					report_mismatch($sformatf("char_code %0d, expected %0d",
						char_code, want.code));
				if (last_char !== want.last)
					report_mismatch($sformatf("last_char %b, expected %b on code %0d",
						last_char, want.last, want.code));
				chars_checked++;
			end
		end
	end

	// Watchdog against a hung handshake or characters that never arrive.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d characters outstanding",
				cycle_count, expected_text.size());
			$display("signed_int_to_decimal_ascii_unit test failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		number = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_corner_numbers();
		test_random_lengths(300);
		test_random_patterns(140);

		// Let the last text come out, then watch a while longer for strays.
		while (expected_text.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d numbers (%0d negative), checked %0d characters,",
			numbers_sent, negatives_sent, chars_checked);
		$display("longest text %0d characters, %0d mismatches.", longest_text, mismatches);
		if (mismatches == 0)
			$display("signed_int_to_decimal_ascii_unit test passed");
		else
			$display("signed_int_to_decimal_ascii_unit test failed");
		$finish;
	end

endmodule
